/* rtl/core/ffa_pkg.sv */
// Shared types, widths, codes and defaults of the first-fit heap allocator.
package ffa_pkg;

  localparam int ADDR_W   = 16;
  localparam int SIZE_W   = 16;
  localparam int STATUS_W = 3;
  localparam int LIMIT_W  = 17;
  localparam int PADDR_W  = 3;

  localparam int MAX_CHUNKS_DEF   = 64;
  localparam int HEAP_BYTES_DEF   = 65536;
  localparam int HEADER_BYTES_DEF = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;
  localparam logic [LIMIT_W-1:0] ADDR_SPAN   = 17'h10000;

  // register index, taken from paddr[2]
  localparam logic REG_HEAP_LIMIT = 1'b0;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd4;

  typedef struct packed {
    logic              is_free;
    logic [SIZE_W-1:0] length;
    logic [ADDR_W-1:0] base;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* rtl/core/ffa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/first_fit_heap_allocator.sv */
// First-fit heap allocator: chunk table in RAM, sequential scan per request.
//
// The heap is tiled by an address-ordered table of chunks (base, length,
// free mark) held in one RAM of MAX_CHUNKS entries. An allocate item scans
// the table for the first free chunk that is large enough and marks it used;
// failing that it appends a chunk at the heap top, bounded by the smallest
// of heap_limit, HEAP_BYTES and 64 KiB and by the table depth. A free item
// looks its chunk up by payload address (base + HEADER_BYTES): the last
// chunk is dropped and the top lowers to its base, any other is marked free,
// with no coalescing. One result item per input item. The block works on one
// item at a time: the scan reads one table entry per cycle through the RAM's
// single read port. It stops at the first entry that matches, or walks all
// entries below the chunk count without a match (none on an empty table).
// Zero-size allocates and frees of address zero skip the scan. A finished
// result waits in the output register while the next item is accepted. The
// table needs no clearing after reset; only entries below the chunk count
// are ever read. Register 0 (byte address 0) is heap_limit, 17 bits, reset
// 65536.
module first_fit_heap_allocator #(
  parameter int MAX_CHUNKS   = ffa_pkg::MAX_CHUNKS_DEF,
  parameter int HEAP_BYTES   = ffa_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // request stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [31:0]                  s_tdata,   // request_size[15:0], payload_address[31:16]
  input  logic                         s_tuser,   // command
  // result stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [23:0]                  m_tdata,   // granted_address[15:0], reused[16],
                                                  // heap_shrunk[17], zero pad
  output logic [ffa_pkg::STATUS_W-1:0] m_tuser,   // status
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ffa_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  import ffa_pkg::*;

  localparam int IW = $clog2(MAX_CHUNKS);
  localparam int CW = $clog2(MAX_CHUNKS + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_CHUNKS);
  localparam logic [17:0] HDR = 18'(HEADER_BYTES);
  // growth cap from the heap size and the 16-bit address space
  localparam logic [LIMIT_W-1:0] LIMIT_CAP =
    (HEAP_BYTES < 65536) ? LIMIT_W'(HEAP_BYTES) : ADDR_SPAN;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  // control state
  logic [1:0]          state;
  logic [CW-1:0]       idx;        // next entry to read
  logic                pend;       // a read is in flight for entry pidx
  logic [IW-1:0]       pidx;
  logic [CW-1:0]       count;
  logic [LIMIT_W-1:0]  heap_top;
  logic [LIMIT_W-1:0]  heap_limit;

  // item and result payload
  logic                cmd;
  logic [SIZE_W-1:0]   req_size;
  logic [ADDR_W-1:0]   req_addr;
  logic [STATUS_W-1:0] res_status;
  logic [ADDR_W-1:0]   res_addr;
  logic                res_reused;
  logic                res_shrunk;

  // RAM port
  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  entry_t              ram_wentry;
  logic [ENTRY_W-1:0]  ram_rdata;
  entry_t              rd;

  logic                accept;
  logic                out_free;
  logic                hit;
  logic                is_last;
  logic                scan_done;
  logic [17:0]         payload;
  logic [17:0]         new_top;
  logic [LIMIT_W-1:0]  eff_limit;

  ffa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_CHUNKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .raddr (idx[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd       = entry_t'(ram_rdata);
  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign payload   = {2'b00, rd.base} + HDR;
  assign new_top   = {1'b0, heap_top} + HDR + {2'b00, req_size};
  assign eff_limit = (heap_limit < LIMIT_CAP) ? heap_limit : LIMIT_CAP;
  assign is_last   = (CW'(pidx) + CW'(1)) == count;
  assign scan_done = !pend && (idx == count);

  always_comb begin
    if (!pend) begin
      hit = 1'b0;
    end else if (cmd == CMD_FREE) begin
      hit = (payload == {2'b00, req_addr});
    end else begin
      hit = rd.is_free && (rd.length >= req_size);
    end
  end

  // table writes: mark used, mark free, or append
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = pidx;
    ram_wentry = rd;
    if (state == S_SCAN) begin
      if (hit) begin
        if (cmd == CMD_ALLOC) begin
          ram_we             = 1'b1;
          ram_wentry.is_free = 1'b0;
        end else if (!is_last) begin
          ram_we             = 1'b1;
          ram_wentry.is_free = 1'b1;
        end
      end else if (scan_done && cmd == CMD_ALLOC && new_top <= {1'b0, eff_limit}
                   && count != COUNT_MAX) begin
        ram_we     = 1'b1;
        ram_waddr  = count[IW-1:0];
        ram_wentry = '{is_free: 1'b0, length: req_size, base: heap_top[ADDR_W-1:0]};
      end
    end
  end

  // sequencer and table bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      pend       <= 1'b0;
      count      <= '0;
      heap_top   <= '0;
      heap_limit <= LIMIT_RESET;
      m_tvalid   <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_HEAP_LIMIT) begin
        heap_limit <= pwdata[LIMIT_W-1:0];
      end
      // a new result may replace one taken at the same edge
      if (state == S_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            idx  <= '0;
            pend <= 1'b0;
            if ((s_tuser == CMD_ALLOC && s_tdata[15:0] == '0) ||
                (s_tuser == CMD_FREE && s_tdata[31:16] == '0)) begin
              state <= S_FIN;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            pend  <= 1'b0;
            state <= S_FIN;
            if (cmd == CMD_FREE && is_last) begin
              heap_top <= {1'b0, rd.base};
              count    <= count - CW'(1);
            end
          end else if (scan_done) begin
            state <= S_FIN;
            if (cmd == CMD_ALLOC && new_top <= {1'b0, eff_limit} && count != COUNT_MAX) begin
              heap_top <= new_top[LIMIT_W-1:0];
              count    <= count + CW'(1);
            end
          end else if (idx != count) begin
            pend <= 1'b1;
            idx  <= idx + CW'(1);
          end else begin
            pend <= 1'b0;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item capture, result formation, output register
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd        <= s_tuser;
      req_size   <= s_tdata[15:0];
      req_addr   <= s_tdata[31:16];
      res_addr   <= '0;
      res_reused <= 1'b0;
      res_shrunk <= 1'b0;
      res_status <= (s_tuser == CMD_ALLOC) ? ST_ZERO : ST_OK;
    end
    if (state == S_SCAN) begin
      if (!pend) begin
        pidx <= idx[IW-1:0];
      end else if (!hit) begin
        pidx <= idx[IW-1:0];
      end
      if (hit) begin
        res_status <= ST_OK;
        if (cmd == CMD_ALLOC) begin
          res_addr   <= payload[ADDR_W-1:0];
          res_reused <= 1'b1;
        end else begin
          res_shrunk <= is_last;
        end
      end else if (scan_done) begin
        if (cmd == CMD_FREE) begin
          res_status <= ST_UNKNOWN;
        end else if (new_top > {1'b0, eff_limit}) begin
          res_status <= ST_NOSPACE;
        end else if (count == COUNT_MAX) begin
          res_status <= ST_FULL;
        end else begin
          res_status <= ST_OK;
          res_addr   <= 16'(heap_top + LIMIT_W'(HDR));
        end
      end
    end
    if (state == S_FIN && out_free) begin
      m_tuser <= res_status;
      m_tdata <= {6'b0, res_shrunk, res_reused, res_addr};
    end
  end

  // register read-back
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEAP_LIMIT) ? {{(32 - LIMIT_W){1'b0}}, heap_limit} : '0;

`ifndef SYNTHESIS
  a_top_in_cap: assert property (@(posedge clk) disable iff (rst)
    heap_top <= LIMIT_CAP)
    else $error("heap top beyond address cap");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_MAX)
    else $error("chunk count beyond table depth");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> heap_top == '0)
    else $error("empty table with nonzero heap top");

  a_reuse_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[16] || m_tdata[17]) |-> m_tuser == ST_OK)
    else $error("reuse or shrink flag on a failed request");
`endif

endmodule
